@@ src/sdal_pkg.sv @@
// Package for the slot allocator: request opcodes and result status codes.
// No dependencies; used by slot_allocator_dense_active_list.
package sdal_pkg;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

endpackage

@@ src/sdal_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port with write-through.
// No dependencies; used by slot_allocator_dense_active_list for the slot tables.
module sdal_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/slot_allocator_dense_active_list.sv @@
// Slot allocator with free stack and dense active list; uses sdal_pkg and sdal_ram.
// done is registered behind one register stage for the table reads and one for the result;
// throughput: one transaction per cycle, busy stays low; the single read port of each table RAM
// is forwarded on a write. Reset clears live flags, owner counts, stack depth, high-water mark
// and live count at once; no clearing pass. Results cannot be stalled by the receiver.
module slot_allocator_dense_active_list #(
    parameter int SLOTS  = 64,
    parameter int OWNERS = 4,
    localparam int SW  = $clog2(SLOTS),
    localparam int CW  = $clog2(SLOTS + 1),
    localparam int OWB = (OWNERS > 1) ? $clog2(OWNERS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           opcode,
    input  logic [OWB-1:0] owner,
    input  logic [SW-1:0]  slot_to_free,
    output logic           done,
    output logic [SW-1:0]  slot,
    output logic [1:0]     status,
    output logic [CW-1:0]  live_total,
    output logic [CW-1:0]  owner_live
);

    logic                accept;
    logic [OWB-1:0]      owner_sat;
    logic                slot_in_range;

    logic                req_valid_reg;
    sdal_pkg::opcode_t   req_op_reg;
    logic [OWB-1:0]      req_owner_reg;
    logic [SW-1:0]       req_slot_reg;
    logic                req_in_range_reg;

    logic [CW-1:0]       free_depth_reg;
    logic [CW-1:0]       free_depth_next;
    logic [CW-1:0]       fresh_mark_reg;
    logic [CW-1:0]       fresh_mark_next;
    logic [CW-1:0]       live_count_reg;
    logic [CW-1:0]       live_count_next;
    logic                slot_live_reg [SLOTS];
    logic [CW-1:0]       owner_count_reg [OWNERS];

    logic [CW-1:0]       depth_dec;
    logic [CW-1:0]       live_dec;

    logic                fs_we;
    logic [SW-1:0]       fs_waddr;
    logic [SW-1:0]       fs_wdata;
    logic [SW-1:0]       fs_rdata;
    logic                al_we;
    logic [SW-1:0]       al_waddr;
    logic [SW-1:0]       al_wdata;
    logic [SW-1:0]       al_rdata;
    logic                lp_we;
    logic [SW-1:0]       lp_waddr;
    logic [SW-1:0]       lp_wdata;
    logic [SW-1:0]       lp_rdata;
    logic                so_we;
    logic [SW-1:0]       so_waddr;
    logic [OWB-1:0]      so_wdata;
    logic [OWB-1:0]      so_rdata;

    logic                store_full;
    logic                from_stack;
    logic [SW-1:0]       alloc_slot;
    logic                free_live;
    logic [CW-1:0]       alloc_cnt;
    logic [CW-1:0]       free_cnt;

    logic                live_we;
    logic [SW-1:0]       live_idx;
    logic                live_val;
    logic                cnt_we;
    logic [OWB-1:0]      cnt_idx;
    logic [CW-1:0]       cnt_val;

    logic [SW-1:0]       res_slot;
    sdal_pkg::status_t   res_status;
    logic [CW-1:0]       res_owner_live;

    logic                done_reg;
    logic [SW-1:0]       slot_reg;
    sdal_pkg::status_t   status_reg;
    logic [CW-1:0]       live_total_reg;
    logic [CW-1:0]       owner_live_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign owner_sat     = ({1'b0, owner} >= (OWB + 1)'(OWNERS)) ? OWB'(OWNERS - 1) : owner;
    assign slot_in_range = ({1'b0, slot_to_free} < (SW + 1)'(SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg       <= sdal_pkg::opcode_t'(opcode);
            req_owner_reg    <= owner_sat;
            req_slot_reg     <= slot_to_free;
            req_in_range_reg <= slot_in_range;
        end
    end

    // read addresses follow the state left by the transaction now executing
    assign depth_dec = free_depth_next - CW'(1);
    assign live_dec  = live_count_next - CW'(1);

    sdal_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_stack (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (accept),
        .raddr (depth_dec[SW-1:0]),
        .rdata (fs_rdata)
    );

    sdal_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_active_list (
        .clk   (clk),
        .we    (al_we),
        .waddr (al_waddr),
        .wdata (al_wdata),
        .re    (accept),
        .raddr (live_dec[SW-1:0]),
        .rdata (al_rdata)
    );

    sdal_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_list_position (
        .clk   (clk),
        .we    (lp_we),
        .waddr (lp_waddr),
        .wdata (lp_wdata),
        .re    (accept),
        .raddr (slot_to_free),
        .rdata (lp_rdata)
    );

    sdal_ram #(.WIDTH(OWB), .DEPTH(SLOTS)) u_slot_owner (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .re    (accept),
        .raddr (slot_to_free),
        .rdata (so_rdata)
    );

    assign store_full = (free_depth_reg == '0) && (fresh_mark_reg == CW'(SLOTS));
    assign from_stack = (free_depth_reg != '0);
    assign alloc_slot = from_stack ? fs_rdata : fresh_mark_reg[SW-1:0];
    assign free_live  = req_in_range_reg && slot_live_reg[req_slot_reg];
    assign alloc_cnt  = owner_count_reg[req_owner_reg];
    assign free_cnt   = owner_count_reg[so_rdata];

    always_comb
    begin
        free_depth_next = free_depth_reg;
        fresh_mark_next = fresh_mark_reg;
        live_count_next = live_count_reg;
        fs_we          = 1'b0;
        fs_waddr       = free_depth_reg[SW-1:0];
        fs_wdata       = req_slot_reg;
        al_we          = 1'b0;
        al_waddr       = live_count_reg[SW-1:0];
        al_wdata       = alloc_slot;
        lp_we          = 1'b0;
        lp_waddr       = alloc_slot;
        lp_wdata       = live_count_reg[SW-1:0];
        so_we          = 1'b0;
        so_waddr       = alloc_slot;
        so_wdata       = req_owner_reg;
        live_we        = 1'b0;
        live_idx       = alloc_slot;
        live_val       = 1'b1;
        cnt_we         = 1'b0;
        cnt_idx        = req_owner_reg;
        cnt_val        = alloc_cnt + CW'(1);
        res_slot       = '0;
        res_status     = sdal_pkg::ST_OK;
        res_owner_live = '0;
        if (req_valid_reg)
        begin
            if (req_op_reg == sdal_pkg::OP_ALLOC)
            begin
                if (store_full)
                begin
                    res_status     = sdal_pkg::ST_FULL;
                    res_owner_live = alloc_cnt;
                end
                else
                begin
                    if (from_stack)
                    begin
                        free_depth_next = free_depth_reg - CW'(1);
                    end
                    else
                    begin
                        fresh_mark_next = fresh_mark_reg + CW'(1);
                    end
                    live_count_next = live_count_reg + CW'(1);
                    al_we          = 1'b1;
                    lp_we          = 1'b1;
                    so_we          = 1'b1;
                    live_we        = 1'b1;
                    cnt_we         = 1'b1;
                    res_slot       = alloc_slot;
                    res_owner_live = alloc_cnt + CW'(1);
                end
            end
            else if (!free_live)
            begin
                res_slot   = req_slot_reg;
                res_status = sdal_pkg::ST_NOT_LIVE;
            end
            else
            begin
                // swap-remove: move the last list entry into the freed position
                al_we    = 1'b1;
                al_waddr = lp_rdata;
                al_wdata = al_rdata;
                lp_we    = 1'b1;
                lp_waddr = al_rdata;
                lp_wdata = lp_rdata;
                live_we  = 1'b1;
                live_idx = req_slot_reg;
                live_val = 1'b0;
                cnt_idx  = so_rdata;
                if (free_cnt != '0)
                begin
                    cnt_we  = 1'b1;
                    cnt_val = free_cnt - CW'(1);
                end
                else
                begin
                    cnt_val = free_cnt;
                end
                live_count_next = live_count_reg - CW'(1);
                if ((CW'(req_slot_reg) + CW'(1)) == fresh_mark_reg)
                begin
                    fresh_mark_next = fresh_mark_reg - CW'(1);
                end
                else
                begin
                    fs_we = 1'b1;
                    if (free_depth_reg < CW'(SLOTS))
                    begin
                        free_depth_next = free_depth_reg + CW'(1);
                    end
                end
                res_slot       = req_slot_reg;
                res_owner_live = cnt_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            fresh_mark_reg <= '0;
            live_count_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live_reg[i] <= 1'b0;
            end
            for (int j = 0; j < OWNERS; j++)
            begin
                owner_count_reg[j] <= '0;
            end
        end
        else
        begin
            free_depth_reg <= free_depth_next;
            fresh_mark_reg <= fresh_mark_next;
            live_count_reg <= live_count_next;
            if (live_we)
            begin
                slot_live_reg[live_idx] <= live_val;
            end
            if (cnt_we)
            begin
                owner_count_reg[cnt_idx] <= cnt_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            slot_reg       <= res_slot;
            status_reg     <= res_status;
            live_total_reg <= live_count_next;
            owner_live_reg <= res_owner_live;
        end
    end

    assign done       = done_reg;
    assign slot       = slot_reg;
    assign status     = status_reg;
    assign live_total = live_total_reg;
    assign owner_live = owner_live_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("result strobe missing after accepted transaction");

    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, live_count_reg} + {1'b0, free_depth_reg}) == {1'b0, fresh_mark_reg})
        else $error("live count does not match mark minus stacked slots");

    a_full_means_all_live: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sdal_pkg::ST_FULL)) |-> (live_total == CW'(SLOTS)))
        else $error("store full reported with free slots");

    a_owner_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (owner_live <= live_total))
        else $error("owner count exceeds live total");

endmodule

@@ tb/slot_ledger_pkg.sv @@
// Scoreboard for the slot allocator testbench: predicts grants and frees, checks results.
// Depends on sdal_pkg for the opcode and status codes.
`timescale 1ns / 100ps
package slot_ledger_pkg;

    typedef struct packed {
        logic [5:0]        slot;
        sdal_pkg::status_t status;
        logic [6:0]        live_total;
        logic [6:0]        owner_live;
    } grant_t;

    class slot_ledger;
        bit         live [64];
        logic [1:0] holder [64];
        logic [5:0] free_stack [64];
        int         free_depth;
        int         fresh_mark;
        int         owner_count [4];
        int         live_count;
        grant_t     expected_grants [$];
        int         mismatches;

        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        function automatic logic [5:0] pick_live();
            logic [5:0] pool [$];
            for (int i = 0; i < 64; i++)
            begin
                if (live[i])
                begin
                    pool = {pool, 6'(i)};
                end
            end
            if (pool.size() == 0)
            begin
                return 6'($urandom_range(0, 63));
            end
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function void note_request(sdal_pkg::opcode_t op, logic [1:0] own, logic [5:0] req);
            grant_t     g;
            logic [5:0] s;
            logic [1:0] prev;
            if (op == sdal_pkg::OP_ALLOC)
            begin
                if (free_depth == 0 && fresh_mark == 64)
                begin
                    g = '{6'd0, sdal_pkg::ST_FULL, 7'(live_count), 7'(owner_count[own])};
                end
                else
                begin
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        s = free_stack[free_depth];
                    end
                    else
                    begin
                        s = 6'(fresh_mark);
                        fresh_mark++;
                    end
                    live[s] = 1'b1;
                    holder[s] = own;
                    live_count++;
                    owner_count[own]++;
                    g = '{s, sdal_pkg::ST_OK, 7'(live_count), 7'(owner_count[own])};
                end
            end
            else if (!live[req])
            begin
                g = '{req, sdal_pkg::ST_NOT_LIVE, 7'(live_count), 7'd0};
            end
            else
            begin
                prev = holder[req];
                owner_count[prev]--;
                live[req] = 1'b0;
                live_count--;
                if (int'(req) + 1 == fresh_mark)
                begin
                    fresh_mark--;
                end
                else
                begin
                    free_stack[free_depth] = req;
                    free_depth++;
                end
                g = '{req, sdal_pkg::ST_OK, 7'(live_count), 7'(owner_count[prev])};
            end
            expected_grants = {expected_grants, g};
        endfunction

        task check_result(logic [5:0] slot, logic [1:0] status, logic [6:0] live_total,
                          logic [6:0] owner_live);
            grant_t g;
            if (expected_grants.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
                return;
            end
            g = expected_grants.pop_front();
            if (slot !== g.slot)
            begin
                report_mismatch($sformatf("slot %0d, want %0d", slot, g.slot));
            end
            if (status !== g.status)
            begin
                report_mismatch($sformatf("status %0d, want %0d", status, g.status));
            end
            if (live_total !== g.live_total)
            begin
                report_mismatch($sformatf("live_total %0d, want %0d", live_total,
                                          g.live_total));
            end
            if (owner_live !== g.owner_live)
            begin
                report_mismatch($sformatf("owner_live %0d, want %0d", owner_live,
                                          g.owner_live));
            end
        endtask
    endclass
endpackage

@@ tb/slot_allocator_dense_active_list_tb.sv @@
// Top-level testbench for slot_allocator_dense_active_list: directed and random
// allocate/free traffic in bursts. Depends on sdal_pkg and slot_ledger_pkg.
`timescale 1ns / 100ps
module slot_allocator_dense_active_list_tb;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       opcode;
    logic [1:0] owner;
    logic [5:0] slot_to_free;
    logic       done;
    logic [5:0] slot;
    logic [1:0] status;
    logic [6:0] live_total;
    logic [6:0] owner_live;

    slot_ledger_pkg::slot_ledger ledger = new;
    int         burst_left;

    slot_allocator_dense_active_list uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .owner        (owner),
        .slot_to_free (slot_to_free),
        .done         (done),
        .slot         (slot),
        .status       (status),
        .live_total   (live_total),
        .owner_live   (owner_live)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            ledger.check_result(slot, status, live_total, owner_live);
        end
    end

    task automatic issue_request(sdal_pkg::opcode_t op, logic [1:0] own, logic [5:0] req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        opcode       <= op;
        owner        <= own;
        slot_to_free <= req;
        do @(posedge clk); while (busy);
        ledger.note_request(op, own, req);
    endtask

    initial
    begin
        int alloc_pct;
        int waited;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= sdal_pkg::OP_ALLOC;
        owner        <= 2'd0;
        slot_to_free <= 6'd0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // free on an empty store, then fill a few slots
        issue_request(sdal_pkg::OP_FREE, 2'd3, 6'd0);
        issue_request(sdal_pkg::OP_ALLOC, 2'd0, 6'd63);
        issue_request(sdal_pkg::OP_ALLOC, 2'd1, 6'd0);
        issue_request(sdal_pkg::OP_ALLOC, 2'd2, 6'd21);
        issue_request(sdal_pkg::OP_ALLOC, 2'd3, 6'd42);
        // lower the mark, then stack a slot from the middle
        issue_request(sdal_pkg::OP_FREE, 2'd0, 6'd3);
        issue_request(sdal_pkg::OP_FREE, 2'd0, 6'd1);
        // dead frees: double free and never-granted slot
        issue_request(sdal_pkg::OP_FREE, 2'd2, 6'd1);
        issue_request(sdal_pkg::OP_FREE, 2'd1, 6'd63);
        // reuse from the stack, then fresh
        issue_request(sdal_pkg::OP_ALLOC, 2'd3, 6'd0);
        issue_request(sdal_pkg::OP_ALLOC, 2'd3, 6'd0);
        issue_request(sdal_pkg::OP_FREE, 2'd0, 6'd0);
        issue_request(sdal_pkg::OP_FREE, 2'd0, 6'd2);
        issue_request(sdal_pkg::OP_ALLOC, 2'd1, 6'd0);
        issue_request(sdal_pkg::OP_ALLOC, 2'd2, 6'd0);

        // alternate fill, drain and mixed phases; the first fills the store
        for (int phase = 0; phase < 10; phase++)
        begin
            alloc_pct = (phase == 0) ? 95 : (phase % 3 == 1) ? 20 :
                        (phase % 3 == 2) ? 85 : 50;
            repeat (100)
            begin
                if ($urandom_range(1, 100) <= alloc_pct)
                begin
                    issue_request(sdal_pkg::OP_ALLOC, 2'($urandom), 6'($urandom));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    issue_request(sdal_pkg::OP_FREE, 2'($urandom), 6'($urandom));
                end
                else
                begin
                    issue_request(sdal_pkg::OP_FREE, 2'($urandom), ledger.pick_live());
                end
            end
        end
        start <= 1'b0;

        waited = 0;
        while (ledger.expected_grants.size() != 0 && waited < 100)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (ledger.expected_grants.size() != 0)
        begin
            ledger.report_mismatch("results missing at end of run");
        end
        if (ledger.mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
